FILE: hdl/mll_pkg.sv
// shared types, constants and token codes for the lexer
package mll_pkg;

  localparam int MaxTokenLenDefault = 64;

  localparam logic [3:0] KIND_EOF   = 4'd0;
  localparam logic [3:0] KIND_END   = 4'd1;
  localparam logic [3:0] KIND_READ  = 4'd2;
  localparam logic [3:0] KIND_WRITE = 4'd3;
  localparam logic [3:0] KIND_BEGIN = 4'd4;
  localparam logic [3:0] KIND_ID    = 4'd5;
  localparam logic [3:0] KIND_RPAR  = 4'd6;
  localparam logic [3:0] KIND_PLUS  = 4'd7;
  localparam logic [3:0] KIND_MINUS = 4'd8;
  localparam logic [3:0] KIND_INT   = 4'd9;
  localparam logic [3:0] KIND_SEMI  = 4'd10;
  localparam logic [3:0] KIND_COMMA = 4'd11;
  localparam logic [3:0] KIND_ASSIGN = 4'd12;
  localparam logic [3:0] KIND_LPAR  = 4'd13;
  localparam logic [3:0] KIND_FLOAT = 4'd14;
  localparam logic [3:0] KIND_ERROR = 4'd15;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_FOLLOWER = 3'd1;
  localparam logic [2:0] ERR_POINT    = 3'd2;
  localparam logic [2:0] ERR_COLON    = 3'd3;
  localparam logic [2:0] ERR_UNKNOWN  = 3'd4;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [2:0]  error_code;
    logic [15:0] line;
    logic [11:0] column;
    logic [6:0]  length;
    logic        last_of_run;
  } token_t;

  // room for three tokens from one character, packed in order; the front end fills at most two
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
    token_t     tok2;
  } bundle_t;

endpackage

FILE: hdl/mll_if.sv
// valid/ready channel interfaces for characters and tokens
interface mll_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_input;
  modport source (output valid, character, end_of_input, input ready);
  modport sink (input valid, character, end_of_input, output ready);
endinterface

interface mll_tok_if;
  import mll_pkg::*;
  logic   valid;
  logic   ready;
  token_t tok;
  modport source (output valid, tok, input ready);
  modport sink (input valid, tok, output ready);
endinterface

FILE: hdl/mll_front.sv
// front end: scan state machine, turns one character into a bundle of tokens
module mll_front import mll_pkg::*; #(
  parameter int MAX_TOKEN_LEN = MaxTokenLenDefault
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] character,
  input  logic       end_of_input,
  output bundle_t    bundle
);

  localparam int LenCapI = (MAX_TOKEN_LEN < 127) ? MAX_TOKEN_LEN : 127;
  localparam logic [6:0] LenCap = 7'(LenCapI);

  typedef enum logic [3:0] {
    S_IDLE, S_IDENT, S_INT, S_FRAC, S_EXPI, S_EXPF, S_COLON, S_MINUS, S_COMMENT
  } scan_t;

  scan_t       state_r, state_nxt;
  logic [6:0]  len_r, len_nxt;
  logic [3:0]  cand_r, cand_nxt;
  logic [15:0] line_r, line_nxt;
  logic [11:0] col_r, col_nxt;
  logic [11:0] tcol_r, tcol_nxt;

  // keyword letters by position: BEGIN, END, READ, WRITE
  function automatic logic [7:0] kw_char(input int k, input logic [2:0] p);
    logic [7:0] r;
    r = 8'h00;
    case (k)
      0: case (p) 3'd0: r = "B"; 3'd1: r = "E"; 3'd2: r = "G"; 3'd3: r = "I";
                  3'd4: r = "N"; default: r = 8'h00; endcase
      1: case (p) 3'd0: r = "E"; 3'd1: r = "N"; 3'd2: r = "D";
                  default: r = 8'h00; endcase
      2: case (p) 3'd0: r = "R"; 3'd1: r = "E"; 3'd2: r = "A"; 3'd3: r = "D";
                  default: r = 8'h00; endcase
      3: case (p) 3'd0: r = "W"; 3'd1: r = "R"; 3'd2: r = "I"; 3'd3: r = "T";
                  3'd4: r = "E"; default: r = 8'h00; endcase
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] narrow(input logic [3:0] cand, input logic [6:0] pos,
                                        input logic [7:0] c);
    logic [3:0] r;
    r = cand;
    for (int k = 0; k < 4; k++) begin
      if (pos > 7'd4 || kw_char(k, pos[2:0]) != c || kw_char(k, pos[2:0]) == 8'h00) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  logic is_alpha, is_digit, is_space, is_follow;
  always_comb begin
    is_alpha = (character inside {[8'h41:8'h5A]}) || (character inside {[8'h61:8'h7A]});
    is_digit = character inside {[8'h30:8'h39]};
    is_space = (character == 8'h20) || (character inside {[8'd9:8'd13]});
    is_follow = is_space || (character inside {"=", "+", "-", "/", ";", "*", "(", ")", ","});
  end

  token_t     toks [3];
  logic [1:0] n;

  always_comb begin
    logic [3:0] kind;
    logic [11:0] ecol;
    logic do_flush, do_dispatch, do_extend;
    logic [6:0] blen;
    logic [3:0] bcand;
    logic [15:0] lcur;
    state_nxt = state_r;
    len_nxt = len_r;
    cand_nxt = cand_r;
    line_nxt = line_r;
    col_nxt = col_r;
    tcol_nxt = tcol_r;
    n = 2'd0;
    for (int i = 0; i < 3; i++) toks[i] = '0;
    do_flush = 1'b0;
    do_dispatch = 1'b0;
    do_extend = 1'b0;
    kind = KIND_ID;
    blen = 7'd0;
    bcand = 4'hF;
    lcur = line_r;
    ecol = (col_r < 12'd4095) ? col_r + 12'd1 : 12'd4095;

    if (end_of_input) begin
      do_flush = 1'b1;
    end else begin
      col_nxt = ecol;
      case (state_r)
        S_IDENT: begin
          if (is_alpha || is_digit || character == "_") do_extend = 1'b1;
          else begin do_flush = 1'b1; do_dispatch = 1'b1; end
        end
        S_INT, S_FRAC, S_EXPI, S_EXPF: begin
          if (is_digit) do_extend = 1'b1;
          else if (character == "." && state_r == S_INT) begin
            do_extend = 1'b1; state_nxt = S_FRAC;
          end else if (character == "e" && state_r == S_INT) begin
            do_extend = 1'b1; state_nxt = S_EXPI;
          end else if (character == "e" && state_r == S_FRAC) begin
            do_extend = 1'b1; state_nxt = S_EXPF;
          end else if (is_follow) begin
            do_flush = 1'b1; do_dispatch = 1'b1;
          end else begin
            do_flush = 1'b1;
          end
        end
        S_COLON: begin
          if (character != "=") begin do_flush = 1'b1; do_dispatch = 1'b1; end
        end
        S_MINUS: begin
          if (character != "-") begin do_flush = 1'b1; do_dispatch = 1'b1; end
        end
        S_COMMENT: ;
        default: do_dispatch = 1'b1;
      endcase
    end

    if (do_extend) begin
      cand_nxt = narrow(cand_r, len_r, character);
      len_nxt = (len_r < LenCap) ? len_r + 7'd1 : len_r;
    end

    // pending token out first
    if (do_flush) begin
      for (int k = 0; k < 4; k++) begin
        if (cand_r[k] && len_r == ((k == 1) ? 7'd3 : (k == 2) ? 7'd4 : 7'd5)) begin
          kind = (k == 0) ? KIND_BEGIN : (k == 1) ? KIND_END : (k == 2) ? KIND_READ : KIND_WRITE;
        end
      end
      case (state_r)
        S_IDENT: begin
          toks[0] = '{kind, ERR_NONE, line_r, tcol_r, len_r, 1'b0}; n = 2'd1;
        end
        S_INT, S_EXPI: begin
          toks[0] = '{KIND_INT, ERR_NONE, line_r, tcol_r, len_r, 1'b0}; n = 2'd1;
        end
        S_FRAC, S_EXPF: begin
          toks[0] = '{KIND_FLOAT, ERR_NONE, line_r, tcol_r, len_r, 1'b0}; n = 2'd1;
        end
        S_COLON: begin
          toks[0] = '{KIND_ERROR, ERR_COLON, line_r, tcol_r, 7'd1, 1'b0}; n = 2'd1;
        end
        S_MINUS: begin
          toks[0] = '{KIND_MINUS, ERR_NONE, line_r, tcol_r, 7'd1, 1'b0}; n = 2'd1;
        end
        default: ;
      endcase
      state_nxt = S_IDLE;
    end

    if (end_of_input) begin
      toks[n] = '{KIND_EOF, ERR_NONE, line_r, ecol, 7'd0, 1'b0};
      n = n + 2'd1;
      state_nxt = S_IDLE;
      len_nxt = 7'd0;
      cand_nxt = 4'hF;
      line_nxt = 16'd1;
      col_nxt = 12'd0;
      tcol_nxt = 12'd0;
    end else if (state_r inside {S_INT, S_FRAC, S_EXPI, S_EXPF} && do_flush && !do_dispatch)
    begin
      toks[n] = '{KIND_ERROR,
                  (character == "." && state_r != S_EXPI) ? ERR_POINT : ERR_FOLLOWER,
                  line_r, ecol, 7'd1, 1'b0};
      n = n + 2'd1;
    end else if (state_r == S_COLON && character == "=") begin
      toks[0] = '{KIND_ASSIGN, ERR_NONE, line_r, tcol_r, 7'd2, 1'b0};
      n = 2'd1;
      state_nxt = S_IDLE;
    end else if (state_r == S_MINUS && character == "-") begin
      state_nxt = S_COMMENT;
    end else if (state_r == S_COMMENT) begin
      if (character == 8'h0A) begin
        line_nxt = (line_r < 16'hFFFF) ? line_r + 16'd1 : line_r;
        col_nxt = 12'd0;
        state_nxt = S_IDLE;
      end
    end else if (do_dispatch) begin
      state_nxt = S_IDLE;
      lcur = line_r;
      if (character == 8'h0A) begin
        line_nxt = (line_r < 16'hFFFF) ? line_r + 16'd1 : line_r;
        col_nxt = 12'd0;
      end else if (is_space) begin
      end else if (is_alpha || is_digit || character == ":" || character == "-") begin
        state_nxt = is_alpha ? S_IDENT : is_digit ? S_INT : (character == ":") ? S_COLON
                  : S_MINUS;
        tcol_nxt = ecol;
        bcand = narrow(4'hF, 7'd0, character);
        blen = 7'd1;
        len_nxt = blen;
        cand_nxt = bcand;
      end else begin
        case (character)
          "(": kind = KIND_LPAR;
          ")": kind = KIND_RPAR;
          ";": kind = KIND_SEMI;
          ",": kind = KIND_COMMA;
          "+": kind = KIND_PLUS;
          default: kind = KIND_ERROR;
        endcase
        toks[n] = '{kind, (kind == KIND_ERROR) ? ERR_UNKNOWN : ERR_NONE, lcur, ecol, 7'd1,
                    1'b0};
        n = n + 2'd1;
      end
    end

    if (n != 2'd0) toks[n - 2'd1].last_of_run = 1'b1;
  end

  assign bundle = '{n, toks[0], toks[1], toks[2]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r <= 7'd0;
      cand_r <= 4'hF;
      line_r <= 16'd1;
      col_r <= 12'd0;
      tcol_r <= 12'd0;
    end else if (step) begin
      state_r <= state_nxt;
      len_r <= len_nxt;
      cand_r <= cand_nxt;
      line_r <= line_nxt;
      col_r <= col_nxt;
      tcol_r <= tcol_nxt;
    end
  end

endmodule

FILE: hdl/mll_queue.sv
// small fifo of token bundles between scanner and output
module mll_queue import mll_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_data,
  input  logic    pop,
  output bundle_t head,
  output logic    not_empty,
  output logic    not_full
);

  localparam int Depth = 4;

  bundle_t    mem_r [Depth];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign not_empty = cnt_r != 3'd0;
  assign not_full = cnt_r != 3'(Depth);
  assign head = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
    if (!rst_n) begin
      wp_r <= 2'd0;
      rp_r <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(push) - 3'(pop);
    end
  end

endmodule

FILE: hdl/mll_back.sv
// back end: unrolls a bundle into single tokens on the output channel
module mll_back import mll_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  bundle_t head,
  input  logic    head_valid,
  output logic    pop,
  mll_tok_if.source out_ch
);

  logic [1:0] idx_r;
  token_t     cur;

  always_comb begin
    case (idx_r)
      2'd0: cur = head.tok0;
      2'd1: cur = head.tok1;
      default: cur = head.tok2;
    endcase
  end

  assign out_ch.valid = head_valid;
  assign out_ch.tok = cur;
  assign pop = head_valid && out_ch.ready && (idx_r + 2'd1 == head.count);

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= 2'd0;
    else if (pop) idx_r <= 2'd0;
    else if (head_valid && out_ch.ready) idx_r <= idx_r + 2'd1;
  end

endmodule

FILE: hdl/micro_language_lexer_unit.sv
// top level of the character-stream lexer
// Takes one character per cycle; each character is scanned in the cycle it is
// accepted and its tokens (zero to two) go into a four-entry queue. The output
// side hands out one token per cycle while the output is ready, so a character
// that makes several tokens holds the output for each of them in turn; input is
// held off only when the queue is full. No clearing pass after reset.
module micro_language_lexer_unit import mll_pkg::*; #(
  parameter int MAX_TOKEN_LEN = MaxTokenLenDefault
) (
  input logic clk,
  input logic rst_n,
  mll_char_if.sink  in_ch,
  mll_tok_if.source out_ch
);

  bundle_t    bundle, head;
  logic       step, push, pop, q_ne, q_nf;

  assign in_ch.ready = q_nf;
  assign step = in_ch.valid && q_nf;
  assign push = step && (bundle.count != 2'd0);

  mll_front #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN)) u_front (
    .clk, .rst_n, .step, .character(in_ch.character),
    .end_of_input(in_ch.end_of_input), .bundle
  );

  mll_queue u_queue (
    .clk, .rst_n, .push, .push_data(bundle), .pop, .head,
    .not_empty(q_ne), .not_full(q_nf)
  );

  mll_back u_back (.clk, .rst_n, .head, .head_valid(q_ne), .pop, .out_ch);

  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    step && in_ch.end_of_input |-> push) else $error("eof gave no token");
  a_pop_ne: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_ne) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> q_nf) else $error("push into full queue");

endmodule
